### rtl/lsps_pkg.sv
// Shared codes, reset values and item types for the limit switch position sequencer.
`timescale 1ns / 1ps

package lsps_pkg;

    // Position codes
    localparam logic [2:0] POS_NONE    = 3'd0;
    localparam logic [2:0] POS_HOME    = 3'd1;
    localparam logic [2:0] POS_MID     = 3'd2;
    localparam logic [2:0] POS_UP      = 3'd3;
    localparam logic [2:0] POS_MIDBACK = 3'd4;

    // Status codes
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_TO_MID   = 3'd1;
    localparam logic [2:0] ST_TO_UP    = 3'd2;
    localparam logic [2:0] ST_TO_MIDBK = 3'd3;
    localparam logic [2:0] ST_TO_HOME  = 3'd4;

    // Reset value of the go command byte ('t')
    localparam logic [7:0] GO_CODE_RESET = 8'd116;

    // Bus widths (fields packed from bit 0, padded to whole bytes)
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // One input item
    typedef struct packed {
        logic       back_ready;
        logic       front_ready;
        logic       home_level;
        logic       limit_level;
        logic [7:0] rx;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic       homed;
        logic       magazine_start;
        logic [2:0] moving_to;
        logic [2:0] where_now;
        logic       motor_on;
        logic       drive_rev;
        logic       drive_fwd;
    } out_item_t;

endpackage

### rtl/lsps_core.sv
// Sequencer state registers and per-item next-state logic.
`timescale 1ns / 1ps

module lsps_core
    import lsps_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,       // an item is accepted this cycle
    input  in_item_t  item,
    input  logic [7:0] go_code,
    output out_item_t res_next    // result of the current item
);

    logic       enabled_reg, enabled_next;
    logic       last_limit_reg, last_limit_next;
    logic [2:0] pos_reg, pos_next;
    logic [2:0] st_reg, st_next;
    logic       fwd_reg, fwd_next;
    logic       rev_reg, rev_next;
    logic       motor_reg, motor_next;
    logic       mag;
    logic       limit_edge;
    logic       mags_ready;

    // Next-state logic for one tick
    always_comb begin
        enabled_next    = enabled_reg;
        last_limit_next = last_limit_reg;
        pos_next        = pos_reg;
        st_next         = st_reg;
        fwd_next        = fwd_reg;
        rev_next        = rev_reg;
        motor_next      = motor_reg;
        mag             = 1'b0;
        limit_edge      = (last_limit_reg != item.limit_level);
        mags_ready      = item.front_ready & item.back_ready;

        if (enabled_reg) begin
            last_limit_next = item.limit_level;

            // go command: forward from mid, or from home with magazines ready
            if (item.rx == go_code && st_reg == ST_IDLE &&
                (pos_reg == POS_MID || (pos_reg == POS_HOME && mags_ready))) begin
                fwd_next   = 1'b1;
                rev_next   = 1'b0;
                motor_next = 1'b1;
            end

            // limit high: action depends on status, overrides the go command
            if (item.limit_level) begin
                case (st_reg)
                    ST_TO_UP, ST_TO_MIDBK: begin
                        fwd_next   = 1'b0;
                        rev_next   = 1'b1;
                        motor_next = 1'b1;
                    end
                    ST_TO_MID: begin
                        fwd_next   = 1'b1;
                        rev_next   = 1'b1;
                        motor_next = 1'b0;
                    end
                    ST_TO_HOME: begin
                        fwd_next   = 1'b1;
                        rev_next   = 1'b1;
                        motor_next = 1'b0;
                        mag        = 1'b1;
                    end
                    default: ;
                endcase
            end

            // any limit edge steps the position/status cycle
            if (limit_edge) begin
                if (pos_reg != POS_NONE) begin
                    case (pos_reg)
                        POS_HOME: begin
                            pos_next = POS_NONE;
                            st_next  = ST_TO_MID;
                        end
                        POS_MID: begin
                            pos_next = POS_NONE;
                            st_next  = ST_TO_UP;
                        end
                        POS_UP: begin
                            pos_next = POS_NONE;
                            st_next  = ST_TO_MIDBK;
                        end
                        POS_MIDBACK: begin
                            pos_next = POS_NONE;
                            st_next  = ST_TO_HOME;
                        end
                        default: ;
                    endcase
                end else begin
                    case (st_reg)
                        ST_TO_MID: begin
                            pos_next = POS_MID;
                            st_next  = ST_IDLE;
                        end
                        ST_TO_MIDBK: begin
                            pos_next = POS_MIDBACK;
                            st_next  = ST_IDLE;
                        end
                        ST_TO_UP: begin
                            pos_next = POS_UP;
                            st_next  = ST_IDLE;
                        end
                        ST_TO_HOME: begin
                            pos_next = POS_HOME;
                            st_next  = ST_IDLE;
                        end
                        default: ;
                    endcase
                end
            end
        end else begin
            // homing: reverse until the home pin reads low
            if (!item.home_level) begin
                enabled_next = 1'b1;
                pos_next     = POS_HOME;
                st_next      = ST_IDLE;
                fwd_next     = 1'b1;
                rev_next     = 1'b1;
                motor_next   = 1'b0;
            end else begin
                fwd_next   = 1'b0;
                rev_next   = 1'b1;
                motor_next = 1'b1;
            end
        end
    end

    // State update on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg    <= 1'b0;
            last_limit_reg <= 1'b1;
            pos_reg        <= POS_HOME;
            st_reg         <= ST_IDLE;
            fwd_reg        <= 1'b0;
            rev_reg        <= 1'b1;
            motor_reg      <= 1'b1;
        end else if (step) begin
            enabled_reg    <= enabled_next;
            last_limit_reg <= last_limit_next;
            pos_reg        <= pos_next;
            st_reg         <= st_next;
            fwd_reg        <= fwd_next;
            rev_reg        <= rev_next;
            motor_reg      <= motor_next;
        end
    end

    // Result fields are the state after the tick
    assign res_next.drive_fwd      = fwd_next;
    assign res_next.drive_rev      = rev_next;
    assign res_next.motor_on       = motor_next;
    assign res_next.where_now      = pos_next;
    assign res_next.moving_to      = st_next;
    assign res_next.magazine_start = mag;
    assign res_next.homed          = enabled_next;

    // Once homed, control stays enabled until reset
    a_homed_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        enabled_reg |=> enabled_reg)
        else $error("control enable dropped without reset");

    // A known position always goes with an idle status, no position with a move
    a_pos_st_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg != POS_NONE) == (st_reg == ST_IDLE))
        else $error("position and status codes out of step");

    // Magazine start only comes with a halted motor
    a_mag_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && mag) |=> (!motor_reg && fwd_reg && rev_reg))
        else $error("magazine start without halt");

    // While homing with the home pin high, the drive is reverse
    a_homing_rev: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && !enabled_reg && item.home_level) |=>
            (!fwd_reg && rev_reg && motor_reg && !enabled_reg))
        else $error("homing drive not reverse");

endmodule

### rtl/limit_switch_position_sequencer_top.sv
// Top level of the limit switch position sequencer: handshakes, go code register, result register.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// s_        in         s_tvalid / s_tready    one control tick (command byte, pin levels)
// m_        out        m_tvalid / m_tready    pins, position, status, pulse, homed
// cfg_      in         cfg_valid / cfg_ready  go code byte
//
// One item per clock while the output is not stalled: the next state is computed in one pass
// from the item and the state registers, and the output register captures the result on accept.
// A new item is taken while the output register is empty or being drained.
// Synchronous active-low reset: homing state, reverse drive, go code 116, output empty.
// cfg_ready is always high; write the go code only while the block is idle.

module limit_switch_position_sequencer_top
    import lsps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [7:0] rx, [8] limit_level, [9] home_level, [10] front_ready, [11] back_ready
    input  logic [S_TDATA_W-1:0] s_tdata,
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] drive_fwd, [1] drive_rev, [2] motor_on, [5:3] where_now, [8:6] moving_to,
    // [9] magazine_start, [10] homed
    output logic [M_TDATA_W-1:0] m_tdata,
    // go code register write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data
);

    localparam int IN_W  = $bits(in_item_t);
    localparam int OUT_W = $bits(out_item_t);

    logic [7:0] go_code_reg;
    logic       m_valid_reg;
    out_item_t  res_reg;
    out_item_t  res_next;
    in_item_t   item;
    logic       s_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign item      = in_item_t'(s_tdata[IN_W-1:0]);

    // Go code register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            go_code_reg <= GO_CODE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            go_code_reg <= cfg_data;
        end
    end

    lsps_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (s_accept),
        .item     (item),
        .go_code  (go_code_reg),
        .res_next (res_next)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-OUT_W){1'b0}}, res_reg};

endmodule
